// ----- hdl/multi_queue_shared_buffer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the shared buffer queue unit
// Implication and next-cycle implication checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_UNIT_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MQSB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mqsb assertion failed");

// Next-cycle implication.
`define MQSB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mqsb assertion failed");

`endif

// ----- hdl/mqsb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqsb_pkg
// Sizes, codes and types shared by the shared buffer queue unit.
// ----------------------------------------------------------------------------
package mqsb_pkg;

	localparam int SLOTS  = 16;
	localparam int QUEUES = 4;
	localparam int IW     = $clog2(SLOTS);       // slot index bits
	localparam int SW     = $clog2(SLOTS + 1);   // slot index plus null code
	localparam int QW     = $clog2(QUEUES);
	localparam int DW     = 32;

	localparam logic [SW-1:0] NIL_SLOT = SW'(SLOTS);

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic          en;
		logic [IW-1:0] addr;
		logic [SW-1:0] data;
	} link_wr_t;

endpackage

// ----- hdl/mqsb_link_mem.sv -----
// ----------------------------------------------------------------------------
// mqsb_link_mem
// Next-slot table: one write and one registered read per cycle. Entries not
// yet written read as their reset link, slot i pointing to slot i+1.
// ----------------------------------------------------------------------------
module mqsb_link_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [mqsb_pkg::IW-1:0] rd_addr,
	input  mqsb_pkg::link_wr_t     wr,
	output logic [mqsb_pkg::SW-1:0] rd_data
);
	import mqsb_pkg::*;

	logic [SW-1:0] mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [SW-1:0] rd_data_q;
	logic [IW-1:0] rd_addr_q;
	logic          rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			rd_hit_q <= vld_q[rd_addr];
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	// The last slot's reset link equals the null code.
	assign rd_data = rd_hit_q ? rd_data_q : SW'(rd_addr_q) + SW'(1);

endmodule

// ----- hdl/multi_queue_shared_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit
// Four FIFO queues sharing one sixteen-slot payload store through a linked
// next-slot table and a free list.
// ----------------------------------------------------------------------------
// Each input word is one request: s_tuser selects enqueue (0) or dequeue (1),
// s_tdata carries the queue number and the payload. Every request returns
// exactly one output word with a status in m_tuser: ok, overflow (no free
// slot, the enqueue is dropped) or underflow (empty queue, data all ones);
// an enqueue always returns data zero. Requests are handled one at a time.
// A request goes through the accept and read step, execute and result load
// into the output register; an enqueue to a non-empty queue adds a link step
// between execute and result load, for a second write through the single
// write port of the link table to chain the old tail. The result
// register decouples the output side; if it is still held by the consumer,
// the finished result waits until it drains. No clearing pass is needed after
// reset: the link table resolves unwritten entries through per-slot valid bits.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] queue_id, [33:2] data_in, [39:34] zero
	input  logic        s_tuser,   // [0] req_type
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data_out
	output logic [1:0]  m_tuser    // [1:0] status
);
	import mqsb_pkg::*;

	// Controller state and the captured request.
	fsm_t          state_q, state_nx;
	logic          req_q;
	logic [QW-1:0] qid_q;
	logic [DW-1:0] din_q;
	logic [SW-1:0] slot_q;    // free head for an enqueue, queue head for a dequeue

	// Queue pointers and the free list head live in flops.
	logic [SW-1:0] head_q [QUEUES];
	logic [SW-1:0] tail_q [QUEUES];
	logic [SW-1:0] free_head_q;

	// Payload store: written on enqueue, read at acceptance.
	logic [DW-1:0] pay_mem [SLOTS];
	logic [DW-1:0] pay_rd_q;

	// Result waiting for the output register, and the output register itself.
	logic [DW-1:0] res_data_q;
	status_t       res_status_q;
	logic          out_vld_q;
	logic [DW-1:0] out_data_q;
	status_t       out_status_q;

	// Request fields as they arrive.
	logic          req_in;
	logic [QW-1:0] qid_in;
	logic [DW-1:0] din_in;
	logic          accept;
	logic [SW-1:0] rd_slot;

	// Link table access.
	link_wr_t      link_wr;
	logic [SW-1:0] link_rd;

	// Update strobes from the output decode.
	logic          hd_we, tl_we, fh_we, pay_we, res_ld, out_ld;
	logic [SW-1:0] hd_val, tl_val, fh_val;
	logic [DW-1:0] res_data_nx;
	status_t       res_status_nx;

	logic          q_empty;

	assign req_in  = s_tuser;
	assign qid_in  = s_tdata[QW-1:0];
	assign din_in  = s_tdata[QW+DW-1:QW];
	assign s_tready = (state_q == S_IDLE);
	assign accept  = s_tvalid && s_tready;

	// The slot read at acceptance: the free list head for an enqueue, the
	// queue's head for a dequeue. A null slot reads garbage that is unused.
	assign rd_slot = (req_in == REQ_ENQ) ? free_head_q : head_q[qid_in];
	assign q_empty = (head_q[qid_q] == NIL_SLOT);

	mqsb_link_mem u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_slot[IW-1:0]),
		.wr      (link_wr),
		.rd_data (link_rd)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (req_q == REQ_ENQ && slot_q != NIL_SLOT && !q_empty) begin
					state_nx = S_LINK;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_LINK: begin
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (!out_vld_q || m_tready) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Per-state actions. The execute cycle sees the link and payload words
	// read at acceptance; no write happens in the idle state, so those reads
	// always see the previous request's updates.
	always_comb begin
		link_wr       = '0;
		hd_we         = 1'b0;
		hd_val        = link_rd;
		tl_we         = 1'b0;
		tl_val        = slot_q;
		fh_we         = 1'b0;
		fh_val        = link_rd;
		pay_we        = 1'b0;
		res_ld        = 1'b0;
		res_data_nx   = '0;
		res_status_nx = ST_OK;
		out_ld        = 1'b0;
		case (state_q)
			S_EXEC: begin
				res_ld = 1'b1;
				if (req_q == REQ_ENQ) begin
					if (slot_q == NIL_SLOT) begin
						res_status_nx = ST_OVERFLOW;
					end else begin
						fh_we        = 1'b1;
						pay_we       = 1'b1;
						link_wr.en   = 1'b1;
						link_wr.addr = slot_q[IW-1:0];
						link_wr.data = NIL_SLOT;
						// An empty queue takes the slot as head and tail at
						// once; otherwise the tail moves in the link cycle.
						if (q_empty) begin
							hd_we  = 1'b1;
							hd_val = slot_q;
							tl_we  = 1'b1;
						end
					end
				end else begin
					if (slot_q == NIL_SLOT) begin
						res_status_nx = ST_UNDERFLOW;
						res_data_nx   = {DW{1'b1}};
					end else begin
						hd_we        = 1'b1;
						fh_we        = 1'b1;
						fh_val       = slot_q;
						link_wr.en   = 1'b1;
						link_wr.addr = slot_q[IW-1:0];
						link_wr.data = free_head_q;
						res_data_nx  = pay_rd_q;
					end
				end
			end
			S_LINK: begin
				// Chain the new slot behind the old tail.
				link_wr.en   = 1'b1;
				link_wr.addr = tail_q[qid_q][IW-1:0];
				link_wr.data = slot_q;
				tl_we        = 1'b1;
			end
			S_DONE: begin
				out_ld = !out_vld_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_in;
			qid_q    <= qid_in;
			din_q    <= din_in;
			slot_q   <= rd_slot;
			pay_rd_q <= pay_mem[rd_slot[IW-1:0]];
		end
		if (pay_we) begin
			pay_mem[slot_q[IW-1:0]] <= din_q;
		end
		if (res_ld) begin
			res_data_q   <= res_data_nx;
			res_status_q <= res_status_nx;
		end
		if (out_ld) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= NIL_SLOT;
				tail_q[i] <= NIL_SLOT;
			end
		end else begin
			state_q <= state_nx;
			if (fh_we) begin
				free_head_q <= fh_val;
			end
			if (hd_we) begin
				head_q[qid_q] <= hd_val;
			end
			if (tl_we) begin
				tail_q[qid_q] <= tl_val;
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule

// ----- hdl/mqsb_checker.sv -----
// ----------------------------------------------------------------------------
// mqsb_checker
// Port-level checks of the shared buffer queue unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_unit_assert.svh"

module mqsb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import mqsb_pkg::*;

	// A stalled result holds its value.
	`MQSB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Requests are taken one at a time, so no two are accepted back to back.
	`MQSB_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

	// An underflow always answers all ones.
	`MQSB_ASSERT_IMP(a_underflow_data, m_tvalid && m_tuser == ST_UNDERFLOW, m_tdata == 32'hFFFF_FFFF)

	// An overflow is an enqueue and answers zero.
	`MQSB_ASSERT_IMP(a_overflow_data, m_tvalid && m_tuser == ST_OVERFLOW, m_tdata == 32'd0)

endmodule

bind multi_queue_shared_buffer_unit mqsb_checker u_mqsb_checker (.*);

// ----- tb/sv/tb_multi_queue_shared_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for multi_queue_shared_buffer_unit
// Drives enqueue and dequeue requests into the request stream and checks
// every result word against a linked-list predictor of the four queues and
// their shared slot store. Both stream sides idle at random, the result side
// is held off long enough to back the block up, and the request side pauses
// until the block has drained.
// ----------------------------------------------------------------------------
module tb_multi_queue_shared_buffer_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import mqsb_pkg::*;

	// Cycles with no word moving on either side before the run is abandoned.
	// The longest legal quiet stretch is the long hold-off below plus one
	// idle gap, far under this.
	localparam int unsigned STALL_LIMIT  = 3000;
	// Cycles allowed after the last result.
	localparam int unsigned SETTLE_TIME  = 16;
	localparam int unsigned LONG_HOLD    = 250;
	localparam int unsigned MAX_REPORTS  = 40;

	typedef struct {
		logic [31:0] data;
		status_t     status;
	} result_t;

	// DUT connections. Every input has a known value from time zero.
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // [1:0] queue_id, [33:2] data_in, [39:34] zero
	logic        s_tuser  = 1'b0; // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] data_out
	logic [1:0]  m_tuser;         // [1:0] status

	// Predictor state: payload and next-slot link per slot, first and last
	// slot per queue, and the top of the free list. NIL_SLOT marks an end.
	logic [31:0]   slot_word [SLOTS];
	logic [SW-1:0] slot_next [SLOTS];
	logic [SW-1:0] q_first   [QUEUES];
	logic [SW-1:0] q_last    [QUEUES];
	logic [SW-1:0] free_top;
	int            used_slots;

	// Results still owed by the block, oldest first.
	result_t pending_results[$];
	result_t want;

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;

	// Idling switches for the request and result sides.
	bit src_idle  = 1'b1;
	bit sink_idle = 1'b1;

	// A test asks for a long hold-off by setting hold_len and bumping
	// hold_seq; the result-side process notices the change and counts the
	// hold down itself.
	int unsigned hold_len  = 0;
	int unsigned hold_seq  = 0;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned sink_wait;
	int unsigned sink_draw;

	multi_queue_shared_buffer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic bit is_slot(logic [SW-1:0] s);
		return s < SW'(SLOTS);
	endfunction

	// Free list threads every slot in order; all queues start empty.
	function automatic void clear_queues();
		for (int i = 0; i < SLOTS; i++) begin
			slot_word[i] = '0;
			slot_next[i] = SW'(i + 1);
		end
		slot_next[SLOTS-1] = NIL_SLOT;
		for (int i = 0; i < QUEUES; i++) begin
			q_first[i] = NIL_SLOT;
			q_last[i]  = NIL_SLOT;
		end
		free_top   = '0;
		used_slots = 0;
	endfunction

	// Applies one request to the linked lists and returns the word the block
	// has to answer with.
	function automatic result_t model_request(logic kind, logic [1:0] qid,
			logic [31:0] word);
		result_t       r;
		logic [SW-1:0] slot;
		r.data   = '0;
		r.status = ST_OK;
		if (kind == REQ_ENQ) begin
			slot = free_top;
			if (int'(qid) >= QUEUES || !is_slot(slot)) begin
				// No free slot: the request is dropped and nothing moves.
				r.status = ST_OVERFLOW;
			end else begin
				free_top = slot_next[slot[IW-1:0]];
				if (!is_slot(q_first[qid])) begin
					q_first[qid] = slot;
				end else if (is_slot(q_last[qid])) begin
					slot_next[q_last[qid][IW-1:0]] = slot;
				end
				slot_next[slot[IW-1:0]] = NIL_SLOT;
				q_last[qid]             = slot;
				slot_word[slot[IW-1:0]] = word;
				used_slots++;
			end
		end else begin
			if (int'(qid) >= QUEUES || !is_slot(q_first[qid])) begin
				// Empty queue: answer all ones. The last pointer of a queue that
				// ran empty stays stale and is never looked at.
				r.status = ST_UNDERFLOW;
				r.data   = '1;
			end else begin
				slot                    = q_first[qid];
				q_first[qid]            = slot_next[slot[IW-1:0]];
				slot_next[slot[IW-1:0]] = free_top;
				free_top                = slot;
				r.data                  = slot_word[slot[IW-1:0]];
				used_slots--;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request word, after a random gap when idling is on, and
	// records the expected answer at the edge where the word is taken.
	task automatic send_request(logic kind, logic [1:0] qid, logic [31:0] word);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'b0, word, qid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(model_request(kind, qid, word));
	endtask

	// One random request. enq_pct biases toward enqueue; most dequeues aim
	// at a queue that holds something so the lists get exercised deeply.
	task automatic send_random(int unsigned enq_pct);
		logic [1:0] qid;
		logic       kind;
		qid  = 2'($urandom_range(0, QUEUES - 1));
		kind = ($urandom_range(1, 100) <= enq_pct) ? REQ_ENQ : REQ_DEQ;
		if (kind == REQ_DEQ && used_slots != 0 && $urandom_range(1, 100) <= 85) begin
			while (!is_slot(q_first[qid])) qid = qid + 2'd1;
		end
		send_request(kind, qid, $urandom());
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: ready pattern, checker, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			sink_wait <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= hold_len;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= (hold_left == 1);
		end else if (m_tvalid && m_tready) begin
			// A word leaves now; draw the wait before taking the next one.
			sink_draw = sink_idle ? $urandom_range(0, 15) : 0;
			sink_wait <= sink_draw;
			m_tready  <= (sink_draw == 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_tready  <= (sink_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what);
		if (mismatches < MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Outputs are sampled at the edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result data %h status %0d",
					m_tdata, m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.data)
					report_mismatch($sformatf("data_out %h, expected %h", m_tdata, want.data));
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", m_tuser,
						want.status));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corner payloads, every queue, the full store, an empty queue and a
	// queue reused after it ran dry.
	task automatic test_directed();
		logic [31:0] corner_words [6];
		logic [31:0] word;
		corner_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		// Dequeue from a queue that never held anything.
		send_request(REQ_DEQ, 2'd2, $urandom());
		// Fill every slot, spread over all four queues.
		for (int i = 0; i < SLOTS; i++) begin
			word = (i < 6) ? corner_words[i] : $urandom();
			send_request(REQ_ENQ, 2'(i % QUEUES), word);
		end
		// Store full: this one must be dropped.
		send_request(REQ_ENQ, 2'd1, 32'hDEAD_BEEF);
		// Empty queue 0 completely, then once more to hit underflow.
		for (int i = 0; i < SLOTS / QUEUES + 1; i++)
			send_request(REQ_DEQ, 2'd0, $urandom());
		// Queue 0 starts again with a stale last pointer.
		send_request(REQ_ENQ, 2'd0, 32'h0F0F_F0F0);
	endtask

	// Phases that lean toward filling or toward draining, so the store swings
	// between full and empty. Idling on either side switches per phase.
	task automatic test_random_traffic(int unsigned count);
		int unsigned left;
		int unsigned run;
		int unsigned bias;
		left = count;
		while (left != 0) begin
			run       = $urandom_range(20, 60);
			bias      = ($urandom_range(0, 1) != 0) ? 75 : 25;
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			if (run > left)
				run = left;
			repeat (run) send_random(bias);
			left -= run;
		end
	endtask

	// The result side stops for a long stretch while requests keep coming,
	// so the output register fills and the block refuses further requests.
	task automatic test_output_backpressure();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		hold_len  = LONG_HOLD;
		hold_seq++;
		repeat (40) send_random(60);
		sink_idle = 1'b1;
	endtask

	// The request side goes quiet until every answer is back, then resumes.
	task automatic test_drain_pause();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		repeat (30) send_random(65);
		wait_drained();
		repeat (30) send_random(35);
	endtask

	// No idle gaps on either side.
	task automatic test_full_rate();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		repeat (150) send_random(70);
		repeat (150) send_random(30);
	endtask

	initial begin
		clear_queues();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(600);
		test_output_backpressure();
		test_drain_pause();
		test_full_rate();
		test_random_traffic(350);

		wait_drained();
		repeat (SETTLE_TIME) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
